>>> hw/rtl/gpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpd_pkg: shared types and constants of the gait phase detector
// Phase encoding, threshold bundle, per-leg flags and the phase transition
// function used by the phase update logic.
// ----------------------------------------------------------------------------
package gpd_pkg;

  localparam int LoadW  = 16;
  localparam int PosW   = 16;
  localparam int LevelW = 16;
  localparam int SpanW  = 15;
  localparam int FracW  = 14;
  localparam int ProdW  = SpanW + 1 + LevelW;
  localparam int ThrW   = ProdW - FracW;
  localparam int CodeW  = 3;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 2 * LoadW + 2 * PosW;
  localparam int OutDataW = 8;

  // register indexes of the configuration port
  localparam logic [CfgAddrW-1:0] RegStanceLoad = 3'd0;
  localparam logic [CfgAddrW-1:0] RegSwingLoad  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegLanding    = 3'd2;
  localparam logic [CfgAddrW-1:0] RegLateStance = 3'd3;
  localparam logic [CfgAddrW-1:0] RegLiftoff    = 3'd4;
  localparam logic [CfgAddrW-1:0] RegLegSpan    = 3'd5;

  // register defaults
  localparam int RstStanceLoad  = 1638;
  localparam int RstSwingLoad   = 1638;
  localparam int RstLanding     = 0;
  localparam int RstLateStance  = 0;
  localparam int RstLiftoff     = -16384;
  localparam int RstLegSpan     = 9000;
  localparam int RstLandingThr  = (RstLegSpan * RstLanding) >>> FracW;
  localparam int RstLateThr     = (RstLegSpan * RstLateStance) >>> FracW;
  localparam int RstLiftoffThr  = (RstLegSpan * RstLiftoff) >>> FracW;

  // external phase codes
  localparam logic [CodeW-1:0] CodeUnknown = 3'd0;
  localparam logic [CodeW-1:0] CodeEarly   = 3'd1;
  localparam logic [CodeW-1:0] CodeLate    = 3'd2;
  localparam logic [CodeW-1:0] CodeLiftoff = 3'd3;
  localparam logic [CodeW-1:0] CodeSwing   = 3'd4;
  localparam logic [CodeW-1:0] CodeLanding = 3'd5;

  typedef enum logic [5:0] {
    PhUnknown = 6'b000001,
    PhEarly   = 6'b000010,
    PhLate    = 6'b000100,
    PhLiftoff = 6'b001000,
    PhSwing   = 6'b010000,
    PhLanding = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [LoadW-1:0]       stance_load;
    logic [LoadW-1:0]       swing_load;
    logic signed [ThrW-1:0] landing_thr;
    logic signed [ThrW-1:0] late_thr;
    logic signed [ThrW-1:0] liftoff_thr;
  } thr_t;

  typedef struct packed {
    logic                   stance;
    logic                   swing;
    logic                   late;
    logic                   lift;
    logic                   land;
    logic signed [PosW-1:0] pos;
  } leg_flags_t;

  function automatic leg_flags_t eval_leg(input logic [LoadW-1:0] load,
                                          input logic signed [PosW-1:0] pos,
                                          input thr_t thr);
    leg_flags_t f;
    logic signed [ThrW-1:0] pos_x;
    pos_x    = ThrW'(pos);
    f.pos    = pos;
    f.stance = load > thr.stance_load;
    f.swing  = load <= thr.swing_load;
    f.late   = pos_x < thr.late_thr;
    f.lift   = pos_x < thr.liftoff_thr;
    f.land   = pos_x > thr.landing_thr;
    return f;
  endfunction

  function automatic phase_e next_phase(input phase_e cur, input leg_flags_t me,
                                        input leg_flags_t other);
    logic   behind;
    phase_e nxt;
    behind = other.stance && (me.pos < other.pos);
    nxt    = cur;
    unique case (cur)
      PhEarly: begin
        if (behind) nxt = PhLiftoff;
        else if (me.late) nxt = PhLate;
      end
      PhLate: begin
        if (behind || me.lift) nxt = PhLiftoff;
      end
      PhLiftoff: begin
        if (me.swing) nxt = PhSwing;
      end
      PhSwing: begin
        if (me.stance && (me.pos > other.pos)) nxt = PhEarly;
        else if (!me.stance && me.land) nxt = PhLanding;
      end
      PhLanding: begin
        if (me.stance) nxt = PhEarly;
      end
      default: begin
        if (me.stance) begin
          if (behind) nxt = PhLiftoff;
          else if (me.late) nxt = PhLate;
          else nxt = PhEarly;
        end else begin
          nxt = me.land ? PhLanding : PhSwing;
        end
      end
    endcase
    return nxt;
  endfunction

  function automatic logic [CodeW-1:0] phase_code(input phase_e ph);
    logic [CodeW-1:0] c;
    unique case (ph)
      PhEarly:   c = CodeEarly;
      PhLate:    c = CodeLate;
      PhLiftoff: c = CodeLiftoff;
      PhSwing:   c = CodeSwing;
      PhLanding: c = CodeLanding;
      default:   c = CodeUnknown;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/gait_phase_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gait_phase_detector_top: two-leg gait phase detector
//
//   channel   dir  handshake          payload
//   s_axis    in   tvalid / tready    load_left, load_right, pos_left, pos_right
//   m_axis    out  tvalid / tready    phase_left, phase_right, changed_*
//   cfg       in   cfg_we_i           cfg_addr_i, cfg_wdata_i
//
// An item waits in the input register, the phase logic runs from there into
// the result register: one item per cycle while the result is not stalled.
// The phase state commits as the item moves into the result register.
// A stalled result holds; the input register still takes an item while empty.
// Reset returns both legs to unknown and the configuration registers to defaults.
// ----------------------------------------------------------------------------
module gait_phase_detector_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // load_left[15:0], load_right[31:16], pos_left[47:32], pos_right[63:48]
  input  logic [gpd_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // phase_left[2:0], phase_right[5:3], changed_left[6], changed_right[7]
  output logic [gpd_pkg::OutDataW-1:0]      m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [gpd_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [gpd_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  logic                           in_v_q, out_v_q, adv, take;
  logic [gpd_pkg::InDataW-1:0]    in_q;
  logic [gpd_pkg::OutDataW-1:0]   res, out_q;
  gpd_pkg::thr_t                  thr;

  gpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .thr_o       (thr)
  );

  gpd_phase u_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .sample_i (in_q),
    .thr_i    (thr),
    .result_o (res)
  );

  // advance when the result register is empty or being drained
  assign adv           = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || adv;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (take) in_v_q <= 1'b1;
      else if (adv) in_v_q <= 1'b0;
      if (adv) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) in_q <= s_axis_tdata;
    if (adv) out_q <= res;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

>>> hw/rtl/gpd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpd_cfg: configuration registers and position thresholds
// Holds the six registers and keeps leg length times each position level,
// floored to whole 0.1 mm, in registers of their own.
// ----------------------------------------------------------------------------
module gpd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gpd_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [gpd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output gpd_pkg::thr_t                 thr_o
);

  logic [gpd_pkg::LoadW-1:0]         stance_q, swing_q;
  logic signed [gpd_pkg::LevelW-1:0] landing_q, late_q, liftoff_q;
  logic [gpd_pkg::SpanW-1:0]         span_q;
  logic signed [gpd_pkg::ProdW-1:0]  landing_p, late_p, liftoff_p;
  logic signed [gpd_pkg::SpanW:0]    span_s;
  gpd_pkg::thr_t                     thr_q, thr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stance_q  <= gpd_pkg::LoadW'(gpd_pkg::RstStanceLoad);
      swing_q   <= gpd_pkg::LoadW'(gpd_pkg::RstSwingLoad);
      landing_q <= gpd_pkg::LevelW'(gpd_pkg::RstLanding);
      late_q    <= gpd_pkg::LevelW'(gpd_pkg::RstLateStance);
      liftoff_q <= gpd_pkg::LevelW'(gpd_pkg::RstLiftoff);
      span_q    <= gpd_pkg::SpanW'(gpd_pkg::RstLegSpan);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        gpd_pkg::RegStanceLoad: stance_q  <= cfg_wdata_i;
        gpd_pkg::RegSwingLoad:  swing_q   <= cfg_wdata_i;
        gpd_pkg::RegLanding:    landing_q <= cfg_wdata_i;
        gpd_pkg::RegLateStance: late_q    <= cfg_wdata_i;
        gpd_pkg::RegLiftoff:    liftoff_q <= cfg_wdata_i;
        gpd_pkg::RegLegSpan:    span_q    <= cfg_wdata_i[gpd_pkg::SpanW-1:0];
        default: ;
      endcase
    end
  end

  assign span_s    = {1'b0, span_q};
  assign landing_p = span_s * landing_q;
  assign late_p    = span_s * late_q;
  assign liftoff_p = span_s * liftoff_q;

  // arithmetic shift floors toward minus infinity
  always_comb begin
    thr_d.stance_load = stance_q;
    thr_d.swing_load  = swing_q;
    thr_d.landing_thr = gpd_pkg::ThrW'(landing_p >>> gpd_pkg::FracW);
    thr_d.late_thr    = gpd_pkg::ThrW'(late_p >>> gpd_pkg::FracW);
    thr_d.liftoff_thr = gpd_pkg::ThrW'(liftoff_p >>> gpd_pkg::FracW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.stance_load <= gpd_pkg::LoadW'(gpd_pkg::RstStanceLoad);
      thr_q.swing_load  <= gpd_pkg::LoadW'(gpd_pkg::RstSwingLoad);
      thr_q.landing_thr <= gpd_pkg::ThrW'(gpd_pkg::RstLandingThr);
      thr_q.late_thr    <= gpd_pkg::ThrW'(gpd_pkg::RstLateThr);
      thr_q.liftoff_thr <= gpd_pkg::ThrW'(gpd_pkg::RstLiftoffThr);
    end else begin
      thr_q <= thr_d;
    end
  end

  assign thr_o = thr_q;

endmodule

>>> hw/rtl/gpd_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpd_phase: per-leg phase state and transition logic
// Evaluates both legs from one sample and the phases held before it, and
// commits the new phases when the item advances.
// ----------------------------------------------------------------------------
module gpd_phase (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic [gpd_pkg::InDataW-1:0]       sample_i,
  input  gpd_pkg::thr_t                     thr_i,
  output logic [gpd_pkg::OutDataW-1:0]      result_o
);

  gpd_pkg::phase_e     left_q, right_q, left_d, right_d;
  gpd_pkg::leg_flags_t fl, fr;
  logic [gpd_pkg::LoadW-1:0] load_l, load_r;
  logic signed [gpd_pkg::PosW-1:0] pos_l, pos_r;

  assign load_l = sample_i[15:0];
  assign load_r = sample_i[31:16];
  assign pos_l  = sample_i[47:32];
  assign pos_r  = sample_i[63:48];

  always_comb begin
    fl      = gpd_pkg::eval_leg(load_l, pos_l, thr_i);
    fr      = gpd_pkg::eval_leg(load_r, pos_r, thr_i);
    left_d  = gpd_pkg::next_phase(left_q, fl, fr);
    right_d = gpd_pkg::next_phase(right_q, fr, fl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= gpd_pkg::PhUnknown;
      right_q <= gpd_pkg::PhUnknown;
    end else if (adv_i) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign result_o = {right_d != right_q, left_d != left_q,
                     gpd_pkg::phase_code(right_d), gpd_pkg::phase_code(left_d)};

endmodule

>>> bench/gait_phase_detector_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gait_phase_detector_top_test: self-checking bench of the gait phase detector
// Streams left/right load and position samples through the detector under a
// series of register settings and handshake pressure. A tracker predicts both
// leg phases and change flags per sample and checks each result item in order.
// ----------------------------------------------------------------------------
module gait_phase_detector_top_test;
  import gpd_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 8;
  localparam int SegItems    = 203;
  localparam int NumSegs     = 8;
  localparam int NumDirected = 22;

  // load_left, load_right, pos_left, pos_right
  localparam int Directed [NumDirected][4] = '{
    '{65535, 65535, -5, 3},
    '{0, 65535, -5, 3},
    '{1638, 1639, -9000, -9000},
    '{1639, 1638, -9001, -9001},
    '{0, 0, 32767, -32768},
    '{65535, 65535, 32767, -32768},
    '{65535, 65535, 0, 0},
    '{65535, 65535, -1, 0},
    '{1638, 65535, 1, 0},
    '{1639, 0, 1, -1},
    '{20000, 0, -1, 1},
    '{20000, 0, -9000, 1},
    '{20000, 0, -9001, 1},
    '{0, 20000, -9001, 5},
    '{0, 20000, 32767, 5},
    '{65535, 20000, -32768, -32768},
    '{0, 0, -32768, 32767},
    '{65535, 0, 0, 1},
    '{65535, 65535, 0, -1},
    '{0, 65535, 0, -9001},
    '{0, 0, 0, 0},
    '{30000, 30000, 100, -100}
  };

  typedef struct {
    bit stance;
    bit swing;
    bit late;
    bit lift;
    bit land;
    int pos;
  } leg_view_t;

  typedef struct {
    logic [CodeW-1:0] ph_l;
    logic [CodeW-1:0] ph_r;
    logic             chg_l;
    logic             chg_r;
  } phase_pair_t;

  class gait_phase_tracker;
    int stance_lvl  = RstStanceLoad;
    int swing_lvl   = RstSwingLoad;
    int landing_lvl = RstLanding;
    int late_lvl    = RstLateStance;
    int liftoff_lvl = RstLiftoff;
    int span        = RstLegSpan;
    logic [CodeW-1:0] held [2] = '{CodeUnknown, CodeUnknown};
    phase_pair_t due_phases [$];
    int errors = 0;

    function void set_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegStanceLoad: stance_lvl = int'(val);
        RegSwingLoad:  swing_lvl = int'(val);
        RegLanding:    landing_lvl = int'($signed(val));
        RegLateStance: late_lvl = int'($signed(val));
        RegLiftoff:    liftoff_lvl = int'($signed(val));
        RegLegSpan:    span = int'(val[SpanW-1:0]);
        default: ;
      endcase
    endfunction

    // leg length times fraction, floored
    function int threshold(int lvl);
      longint prod;
      prod = longint'(span) * longint'(lvl);
      return int'(prod >>> FracW);
    endfunction

    function leg_view_t view_leg(logic [LoadW-1:0] load, logic [PosW-1:0] pos);
      leg_view_t v;
      v.pos    = int'($signed(pos));
      v.stance = int'(load) > stance_lvl;
      v.swing  = int'(load) <= swing_lvl;
      v.late   = v.pos < threshold(late_lvl);
      v.lift   = v.pos < threshold(liftoff_lvl);
      v.land   = v.pos > threshold(landing_lvl);
      return v;
    endfunction

    function logic [CodeW-1:0] advance_leg(logic [CodeW-1:0] cur, leg_view_t me,
                                           leg_view_t oth);
      bit behind;
      logic [CodeW-1:0] nxt;
      behind = oth.stance && (me.pos < oth.pos);
      nxt = cur;
      case (cur)
        CodeEarly: begin
          if (behind) nxt = CodeLiftoff;
          else if (me.late) nxt = CodeLate;
        end
        CodeLate: begin
          if (behind || me.lift) nxt = CodeLiftoff;
        end
        CodeLiftoff: begin
          if (me.swing) nxt = CodeSwing;
        end
        CodeSwing: begin
          if (me.stance && (me.pos > oth.pos)) nxt = CodeEarly;
          else if (!me.stance && me.land) nxt = CodeLanding;
        end
        CodeLanding: begin
          if (me.stance) nxt = CodeEarly;
        end
        default: begin
          // unknown and the unused codes
          if (me.stance) begin
            if (behind) nxt = CodeLiftoff;
            else if (me.late) nxt = CodeLate;
            else nxt = CodeEarly;
          end else begin
            nxt = me.land ? CodeLanding : CodeSwing;
          end
        end
      endcase
      return nxt;
    endfunction

    function void take_sample(logic [InDataW-1:0] d);
      leg_view_t lv, rv;
      phase_pair_t p;
      lv = view_leg(d[15:0], d[47:32]);
      rv = view_leg(d[31:16], d[63:48]);
      p.ph_l  = advance_leg(held[0], lv, rv);
      p.ph_r  = advance_leg(held[1], rv, lv);
      p.chg_l = p.ph_l != held[0];
      p.chg_r = p.ph_r != held[1];
      held[0] = p.ph_l;
      held[1] = p.ph_r;
      due_phases = {due_phases, p};
    endfunction

    function void check_field(string what, logic [CodeW-1:0] want, logic [CodeW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, what, want, got);
        errors++;
      end
    endfunction

    function void match_phases(logic [OutDataW-1:0] d);
      phase_pair_t p;
      if (due_phases.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $realtime, d);
        errors++;
        return;
      end
      p = due_phases.pop_front();
      check_field("phase_left", p.ph_l, d[2:0]);
      check_field("phase_right", p.ph_r, d[5:3]);
      check_field("changed_left", CodeW'(p.chg_l), CodeW'(d[6]));
      check_field("changed_right", CodeW'(p.chg_r), CodeW'(d[7]));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  gait_phase_tracker tracker = new;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet = 0;
  int gait_pos [2];
  int gait_lead;
  int gait_both;
  int gait_ticks;

  gait_phase_detector_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.match_phases(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    wait (quiet >= QuietLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [InDataW-1:0] pack_sample(int ll, int lr, int pl, int pr);
    return {PosW'(pr), PosW'(pl), LoadW'(lr), LoadW'(ll)};
  endfunction

  function automatic int load_above(int lvl);
    return $urandom_range(65535, clamp(lvl + 1, 0, 65535));
  endfunction

  function automatic int noise_load();
    case ($urandom_range(3))
      0: return int'(16'($urandom));
      1: return clamp(tracker.stance_lvl + $urandom_range(2) - 1, 0, 65535);
      2: return clamp(tracker.swing_lvl + $urandom_range(2) - 1, 0, 65535);
      default: return $urandom_range(1) ? 65535 : 0;
    endcase
  endfunction

  // hit the position thresholds and the other foot on both sides
  function automatic int noise_pos(int near);
    int base;
    case ($urandom_range(5))
      0: base = tracker.threshold(tracker.late_lvl);
      1: base = tracker.threshold(tracker.liftoff_lvl);
      2: base = tracker.threshold(tracker.landing_lvl);
      3: base = near;
      4: return int'($signed(16'($urandom)));
      default: return $urandom_range(1) ? 32767 : -32768;
    endcase
    return clamp(base + $urandom_range(2) - 1, -32768, 32767);
  endfunction

  function automatic logic [InDataW-1:0] noise_sample();
    int pl;
    pl = noise_pos(int'($signed(16'($urandom))));
    return pack_sample(noise_load(), noise_load(), pl, noise_pos(pl));
  endfunction

  // walking: stance foot moves back, swing foot forward, then double support
  function automatic logic [InDataW-1:0] walk_sample();
    int ld [2];
    int stp;
    int trail;
    trail = 1 - gait_lead;
    if (gait_both > 0) begin
      ld[0] = load_above(tracker.stance_lvl);
      ld[1] = load_above(tracker.stance_lvl);
      gait_both--;
      if (gait_both == 0) begin
        gait_lead = trail;
        gait_ticks = 0;
      end
    end else begin
      stp = $urandom_range(600, 20);
      gait_pos[gait_lead] = clamp(gait_pos[gait_lead] - stp, -32768, 32767);
      gait_pos[trail] = clamp(gait_pos[trail] + 2 * stp, -32768, 32767);
      ld[gait_lead] = load_above(tracker.stance_lvl);
      ld[trail] = $urandom_range(tracker.swing_lvl, 0);
      gait_ticks++;
      if (gait_pos[gait_lead] < tracker.threshold(tracker.liftoff_lvl) -
          int'($urandom_range(300)) || gait_ticks > 40) begin
        gait_both = $urandom_range(3, 1);
      end
    end
    return pack_sample(ld[0], ld[1], gait_pos[0], gait_pos[1]);
  endfunction

  task automatic push_sample(input logic [InDataW-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    tracker.take_sample(d);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.due_phases.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // leaves the write strobe high for the next register
  task automatic put_reg(input logic [CfgAddrW-1:0] idx, input int val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= CfgDataW'(val);
    tracker.set_reg(idx, CfgDataW'(val));
    @(negedge clk_i);
  endtask

  task automatic load_regs(input int st, input int sw, input int la, input int lt,
                           input int lo, input int sp);
    put_reg(RegStanceLoad, st);
    put_reg(RegSwingLoad, sw);
    put_reg(RegLanding, la);
    put_reg(RegLateStance, lt);
    put_reg(RegLiftoff, lo);
    put_reg(RegLegSpan, sp);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setting(input int seg);
    case (seg)
      1: load_regs(0, 0, -32768, -32768, -32768, 0);
      2: load_regs(65535, 65535, 32767, 32767, 32767, 32767);
      3: load_regs(3000, 1000, 4000, -2000, -8000, 9000);
      5: load_regs(0, 65535, 32767, -32768, -32768, 32767);
      4, 6: load_regs($urandom_range(20000), $urandom_range(20000),
                      $urandom_range(16384) - 8192, $urandom_range(16384) - 8192,
                      $urandom_range(16384) - 16384, $urandom_range(32767));
      7: load_regs(RstStanceLoad, RstSwingLoad, RstLanding, RstLateStance,
                   RstLiftoff, RstLegSpan);
      default: ;
    endcase
    case (seg % 4)
      0: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        send_idle_pct = 67;
        stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct = 67;
      end
      default: begin
        send_idle_pct = 14;
        stall_pct = 14;
      end
    endcase
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < NumDirected; i++) begin
      push_sample(pack_sample(Directed[i][0], Directed[i][1], Directed[i][2],
                              Directed[i][3]));
    end
    for (int seg = 0; seg < NumSegs; seg++) begin
      drain();
      apply_setting(seg);
      gait_pos = '{0, 0};
      gait_lead = $urandom_range(1);
      gait_both = 0;
      gait_ticks = 0;
      for (int n = 0; n < SegItems; n++) begin
        if ($urandom_range(99) < 70) push_sample(walk_sample());
        else push_sample(noise_sample());
      end
    end
    drain();
    if (tracker.errors == 0 && tracker.due_phases.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
